FILE: src/rsst_pkg.sv
// rsst_pkg: shared constants, types and helpers of the range sum segment tree
`timescale 1ns / 1ps

package rsst_pkg;

  localparam int LEAVES = 1024;
  localparam int IDX_W  = 10;
  localparam int AMT_W  = 31;
  localparam int SUM_W  = 42;
  localparam int NODE_W = $clog2(2 * LEAVES);
  localparam int DEPTH  = 2 * LEAVES;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SUB   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SUM_W-1:0]  sum_t;

  localparam sum_t LEAF_MAX = sum_t'(64'h7FFF_FFFF);
  localparam sum_t SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic  en;
    node_t addr;
    sum_t  data;
  } ram_wr_t;

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

FILE: src/rsst_node_ram.sv
// rsst_node_ram: node sum store, one write port and one registered read port
`timescale 1ns / 1ps

module rsst_node_ram (
  input  logic             clk,
  input  rsst_pkg::ram_wr_t wr,
  input  rsst_pkg::node_t  rd_addr,
  output rsst_pkg::sum_t   rd_data
);
  import rsst_pkg::*;

  sum_t node_mem [DEPTH];
  sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      node_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= node_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/range_sum_segment_tree.sv
// range_sum_segment_tree: segment tree of leaf sums with update and range query
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   in      | in_valid in_stall in_command in_first_index        | sink
//           | in_last_index in_amount                            |
//   out     | out_valid out_stall out_range_sum                  | source
//
// one item at a time, held in a single node memory with a registered read port.
// update: the leaf is read, then written, then each tree level reads the sibling and
// writes the parent. query: each level walked reads the left and the right end, then a
// final add and the output step; only queries give a result, held in an output register.
// after reset a clearing pass writes zero to all 2048 nodes, with in_stall high throughout.
// in_stall is low only while the sequencer is idle; a stalled result holds the last
// query step until the output register frees up.
`timescale 1ns / 1ps

module range_sum_segment_tree (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [rsst_pkg::IDX_W-1:0]   in_first_index,
  input  logic [rsst_pkg::IDX_W-1:0]   in_last_index,
  input  logic [rsst_pkg::AMT_W-1:0]   in_amount,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rsst_pkg::SUM_W-1:0]   out_range_sum
);
  import rsst_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_LEAF_RD = 10'b0000000100,
    S_LEAF_WR = 10'b0000001000,
    S_UP_RD   = 10'b0000010000,
    S_UP_WR   = 10'b0000100000,
    S_Q_LO    = 10'b0001000000,
    S_Q_HI    = 10'b0010000000,
    S_Q_FIN   = 10'b0100000000,
    S_Q_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  node_t  node_r, node_nxt;
  node_t  hi_r, hi_nxt;
  node_t  clr_cnt_r, clr_cnt_nxt;
  sum_t   acc_r, acc_nxt;
  logic   sub_r, sub_nxt;
  logic   pend_r, pend_nxt;
  logic [AMT_W-1:0] amount_r, amount_nxt;
  logic   out_valid_r, out_valid_nxt;
  sum_t   out_sum_r, out_sum_nxt;

  ram_wr_t ram_wr;
  node_t   rd_addr;
  sum_t    rd_data;

  node_t first_ext, last_ext, last_clamp;
  logic  q_empty;
  logic [SUM_W:0] leaf_add;
  sum_t  leaf_new;
  node_t parent;
  logic [NODE_W:0] lo_inc;
  node_t hi_dec, lo_step, hi_step;

  rsst_node_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  // query range set-up from the incoming item
  always_comb begin
    first_ext  = node_t'(in_first_index);
    last_ext   = node_t'(in_last_index);
    last_clamp = (last_ext >= node_t'(LEAVES)) ? node_t'(LEAVES - 1) : last_ext;
    q_empty    = (first_ext >= node_t'(LEAVES)) || (first_ext > last_clamp);
  end

  // leaf arithmetic: add saturates at the leaf limit, subtract floors at zero
  always_comb begin
    leaf_add = {1'b0, rd_data} + (SUM_W + 1)'(amount_r);
    if (sub_r) begin
      leaf_new = (sum_t'(amount_r) >= rd_data) ? '0 : rd_data - sum_t'(amount_r);
    end else begin
      leaf_new = (leaf_add > {1'b0, LEAF_MAX}) ? LEAF_MAX : leaf_add[SUM_W-1:0];
    end
  end

  always_comb begin
    parent  = node_r >> 1;
    lo_inc  = {1'b0, node_r} + (NODE_W + 1)'(1);
    lo_step = lo_inc[NODE_W:1];
    hi_dec  = hi_r - node_t'(1);
    hi_step = hi_dec >> 1;
  end

  always_comb begin
    case (state_r)
      S_LEAF_RD: rd_addr = node_r;
      S_UP_RD:   rd_addr = node_r ^ node_t'(1);
      S_Q_LO:    rd_addr = node_r;
      S_Q_HI:    rd_addr = hi_r;
      default:   rd_addr = node_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    hi_nxt        = hi_r;
    clr_cnt_nxt   = clr_cnt_r;
    acc_nxt       = acc_r;
    sub_nxt       = sub_r;
    pend_nxt      = pend_r;
    amount_nxt    = amount_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    ram_wr.en     = 1'b0;
    ram_wr.addr   = node_r;
    ram_wr.data   = acc_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = clr_cnt_r;
        ram_wr.data = '0;
        clr_cnt_nxt = clr_cnt_r + node_t'(1);
        if (clr_cnt_r == node_t'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          amount_nxt = in_amount;
          sub_nxt    = (in_command == CMD_SUB);
          case (in_command)
            CMD_ADD, CMD_SUB: begin
              if (first_ext < node_t'(LEAVES)) begin
                node_nxt  = first_ext + node_t'(LEAVES);
                state_nxt = S_LEAF_RD;
              end
            end
            CMD_QUERY: begin
              acc_nxt   = '0;
              pend_nxt  = 1'b0;
              node_nxt  = first_ext + node_t'(LEAVES);
              hi_nxt    = last_clamp + node_t'(LEAVES);
              state_nxt = q_empty ? S_Q_FIN : S_Q_LO;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LEAF_RD: begin
        state_nxt = S_LEAF_WR;
      end
      S_LEAF_WR: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = node_r;
        ram_wr.data = leaf_new;
        acc_nxt     = leaf_new;
        state_nxt   = (node_r == node_t'(1)) ? S_IDLE : S_UP_RD;
      end
      S_UP_RD: begin
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        // acc holds the node just written, rd_data its sibling
        ram_wr.en   = 1'b1;
        ram_wr.addr = parent;
        ram_wr.data = sat_add(acc_r, rd_data);
        acc_nxt     = sat_add(acc_r, rd_data);
        node_nxt    = parent;
        state_nxt   = (parent == node_t'(1)) ? S_IDLE : S_UP_RD;
      end
      S_Q_LO: begin
        // rd_data here is the right-end node read in the previous step
        if (pend_r) begin
          acc_nxt = sat_add(acc_r, rd_data);
        end
        state_nxt = S_Q_HI;
      end
      S_Q_HI: begin
        if (node_r[0]) begin
          acc_nxt = sat_add(acc_r, rd_data);
        end
        pend_nxt  = ~hi_r[0];
        node_nxt  = lo_step;
        hi_nxt    = hi_step;
        state_nxt = (lo_step <= hi_step) ? S_Q_LO : S_Q_FIN;
      end
      S_Q_FIN: begin
        if (pend_r) begin
          acc_nxt = sat_add(acc_r, rd_data);
        end
        pend_nxt  = 1'b0;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    hi_r      <= hi_nxt;
    acc_r     <= acc_nxt;
    sub_r     <= sub_nxt;
    amount_r  <= amount_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule

FILE: dv/range_sum_segment_tree_tb.sv
// range_sum_segment_tree_tb: self-checking testbench of the range sum segment tree
`timescale 1ns / 1ps

module range_sum_segment_tree_tb;
  import rsst_pkg::*;

  localparam logic [1:0]       CMD_UNUSED  = 2'd3;
  localparam logic [AMT_W-1:0] AMT_MAX     = '1;
  localparam logic [IDX_W-1:0] LAST_LEAF   = IDX_W'(LEAVES - 1);
  localparam int               CYCLE_LIMIT = 400000;
  localparam int               PHASE_ITEMS = 205;

  // tracks the leaf counters and the sums that queries should return
  class sum_tree_board;
    sum_t tree_sums [DEPTH];
    sum_t expected_sums [$];
    int   errors;

    function new();
      foreach (tree_sums[i]) tree_sums[i] = '0;
      errors = 0;
    endfunction

    function sum_t clip_add(sum_t a, sum_t b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function void bump_leaf(logic [IDX_W-1:0] leaf, logic [AMT_W-1:0] amt, bit lower);
      int unsigned    node;
      logic [SUM_W:0] v;
      if (leaf >= LEAVES) return;
      node = leaf + LEAVES;
      if (lower) begin
        tree_sums[node] = (sum_t'(amt) >= tree_sums[node]) ? '0 :
                          tree_sums[node] - sum_t'(amt);
      end else begin
        v = {1'b0, tree_sums[node]} + (SUM_W + 1)'(amt);
        tree_sums[node] = (v > {1'b0, LEAF_MAX}) ? LEAF_MAX : v[SUM_W-1:0];
      end
      while (node > 1) begin
        node = node >> 1;
        tree_sums[node] = clip_add(tree_sums[2*node], tree_sums[2*node+1]);
      end
    endfunction

    function sum_t span_total(logic [IDX_W-1:0] first, logic [IDX_W-1:0] last);
      int   lo;
      int   hi;
      int   top;
      sum_t acc;
      acc = '0;
      if (first >= LEAVES) return '0;
      top = (last >= LEAVES) ? LEAVES - 1 : last;
      if (first > top) return '0;
      lo = first + LEAVES;
      hi = top + LEAVES;
      // walk both ends upward, taking nodes that stick out of the parent pair
      while (lo <= hi) begin
        if (lo % 2 == 1) acc = clip_add(acc, tree_sums[lo]);
        if (hi % 2 == 0) acc = clip_add(acc, tree_sums[hi]);
        lo = (lo + 1) >> 1;
        hi = (hi - 1) >> 1;
      end
      return acc;
    endfunction

    function void note_input(logic [1:0] cmd, logic [IDX_W-1:0] first,
                             logic [IDX_W-1:0] last, logic [AMT_W-1:0] amt);
      if (cmd == CMD_ADD) begin
        bump_leaf(first, amt, 1'b0);
      end else if (cmd == CMD_SUB) begin
        bump_leaf(first, amt, 1'b1);
      end else if (cmd == CMD_QUERY) begin
        expected_sums = {expected_sums, span_total(first, last)};
      end
    endfunction

    function void check_result(sum_t got);
      sum_t want;
      if (expected_sums.size() == 0) begin
        $error("range_sum: unexpected item, actual %0d", got);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
        $error("range_sum mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic [IDX_W-1:0]   in_first_index;
  logic [IDX_W-1:0]   in_last_index;
  logic [AMT_W-1:0]   in_amount;
  logic               out_valid;
  logic               out_stall;
  logic [SUM_W-1:0]   out_range_sum;

  sum_tree_board board = new();
  int            send_idle_pct;
  int            stall_pct;
  logic          hold_on;
  int            hold_cycles;
  int            cycle_count;
  event          hold_go;

  range_sum_segment_tree dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_range_sum  (out_range_sum)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side: sample with pre-edge values, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_range_sum);
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps going meanwhile
  initial begin
    hold_on <= 1'b0;
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] first,
                           input logic [IDX_W-1:0] last, input logic [AMT_W-1:0] amt);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_first_index <= first;
    in_last_index  <= last;
    in_amount      <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(cmd, first, last, amt);
  endtask

  // stop offering items until every query answer is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_leaf();
    case ($urandom_range(4))
      0: pick_leaf = IDX_W'($urandom_range(3));
      1: pick_leaf = LAST_LEAF - IDX_W'($urandom_range(3));
      2: pick_leaf = IDX_W'(510 + $urandom_range(3));
      default: pick_leaf = IDX_W'($urandom_range(LEAVES - 1));
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(5))
      0: pick_amount = '0;
      1: pick_amount = AMT_MAX;
      2: pick_amount = AMT_W'($urandom_range(255));
      default: pick_amount = AMT_W'($urandom());
    endcase
  endfunction

  // returns 1 when the item is one the block acts on
  task automatic random_item(output bit counted);
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               pick;
    pick = $urandom_range(99);
    a = pick_leaf();
    b = $urandom_range(3) == 0 ? pick_leaf() : IDX_W'($urandom());
    counted = 1'b1;
    if (pick < 38) begin
      send_item(CMD_ADD, a, b, pick_amount());
    end else if (pick < 58) begin
      send_item(CMD_SUB, a, b, pick_amount());
    end else if (pick < 95) begin
      case ($urandom_range(5))
        0: send_item(CMD_QUERY, '0, LAST_LEAF, pick_amount());
        1: send_item(CMD_QUERY, a, a, pick_amount());
        2: send_item(CMD_QUERY, (a > b) ? a : b, (a > b) ? b : a, pick_amount());
        default: send_item(CMD_QUERY, (a < b) ? a : b, (a < b) ? b : a, pick_amount());
      endcase
    end else begin
      send_item(CMD_UNUSED, a, b, pick_amount());
      counted = 1'b0;
    end
  endtask

  initial begin
    int sent;
    bit counted;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_ADD;
    in_first_index <= '0;
    in_last_index  <= '0;
    in_amount      <= '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_cycles    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tree, leaf saturation and floor, edge ranges, unknown command
    send_item(CMD_QUERY, '0, LAST_LEAF, '0);
    send_item(CMD_ADD, '0, '0, AMT_MAX);
    send_item(CMD_ADD, '0, '1, 31'd1);
    send_item(CMD_ADD, LAST_LEAF, '0, AMT_MAX);
    send_item(CMD_ADD, 10'd512, '0, 31'd5);
    send_item(CMD_SUB, 10'd512, '0, 31'd7);
    send_item(CMD_SUB, LAST_LEAF, '0, 31'd1);
    send_item(CMD_QUERY, '0, LAST_LEAF, AMT_MAX);
    send_item(CMD_QUERY, '0, '0, '0);
    send_item(CMD_QUERY, LAST_LEAF, LAST_LEAF, '0);
    send_item(CMD_QUERY, LAST_LEAF, '0, '0);
    send_item(CMD_QUERY, 10'd5, 10'd4, '0);
    send_item(CMD_UNUSED, '0, LAST_LEAF, AMT_MAX);
    send_item(CMD_QUERY, '0, LAST_LEAF, '0);
    send_item(CMD_ADD, 10'd1, '0, '0);
    send_item(CMD_ADD, 10'd341, '0, 31'h2AAA_AAAA);
    send_item(CMD_ADD, 10'd682, '0, 31'h5555_5555);
    send_item(CMD_QUERY, 10'd1, 10'd1022, '0);
    send_item(CMD_QUERY, 10'd341, 10'd682, '0);
    send_item(CMD_SUB, '0, '0, AMT_MAX);
    send_item(CMD_QUERY, '0, 10'd341, '0);
    drain();

    // random phases: no idling with one long receiver hold-off, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 54 : (ph == 3) ? 9 : 0;
      stall_pct     = (ph == 2) ? 54 : (ph == 3) ? 9 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 0 && sent == PHASE_ITEMS / 2) begin
          hold_cycles = 500;
          -> hold_go;
        end
        random_item(counted);
        if (counted) sent++;
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rsst_pkg.sv
src/rsst_node_ram.sv
src/range_sum_segment_tree.sv
dv/range_sum_segment_tree_tb.sv
